// ===== src/text_semigraphic_row_generator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the semigraphic row generator
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TEXT_SEMIGRAPHIC_ROW_GENERATOR_CORE_MACROS_SVH
`define TEXT_SEMIGRAPHIC_ROW_GENERATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Semigraphic row generator package
// Cell geometry constants, the decoded cell row type and the descender table.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam int unsigned CODE_W      = 8;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned LINE_W      = 4;
  localparam int unsigned GLYPH_W     = 7;
  localparam int unsigned GLYPH_DEPTH = 2048;
  localparam int unsigned GADDR_W     = 11;
  localparam int unsigned PIX_W       = 10;
  localparam int unsigned BLOCK_W     = 5;
  localparam int unsigned PAD_W       = PIX_W - GLYPH_W;

  localparam logic [LINE_W-1:0] BAND_1_START = 4'd5;
  localparam logic [LINE_W-1:0] BAND_2_START = 4'd10;
  localparam logic [LINE_W-1:0] CELL_LINES   = 4'd15;
  localparam logic [LINE_W-1:0] GLYPH_ROWS   = 4'd9;
  localparam logic [LINE_W-1:0] DESC_SHIFT   = 4'd3;
  localparam logic [LINE_W-1:0] DESC_END     = 4'd12;

  localparam logic MODE_RENDER = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0]   block_px;
    logic               glyph_sel;
    logic               glyph_blank;
    logic [GADDR_W-1:0] rd_addr;
  } dec_t;

  function automatic logic has_descender(input logic [CHAR_W-1:0] ch);
    logic flag;
    case (ch)
      7'd1, 7'd2, 7'd6, 7'd11, 7'd16, 7'd22, 7'd44, 7'd59,
      7'd103, 7'd106, 7'd112, 7'd113, 7'd121: flag = 1'b1;
      default: flag = 1'b0;
    endcase
    return flag;
  endfunction

endpackage

// ===== src/sgr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle when enabled; a read is registered and holds its data
// while the port is not enabled.
// ----------------------------------------------------------------------------
module sgr_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sgr_decode.sv =====
// ----------------------------------------------------------------------------
// Cell row decoder
// Builds the block graphic row, decides between block and glyph text, and
// forms the glyph store address and the blank flag for the scan line.
// ----------------------------------------------------------------------------
module sgr_decode (
  input  logic [sgr_pkg::CODE_W-1:0] code,
  input  logic [sgr_pkg::LINE_W-1:0] line,
  output sgr_pkg::dec_t              dec
);
  import sgr_pkg::*;

  logic [CHAR_W-1:0] ch;
  logic              desc;
  logic              left_bit;
  logic              right_bit;
  logic              in_cell;
  logic [LINE_W-1:0] row;

  assign ch   = code[CHAR_W-1:0];
  assign desc = has_descender(ch);

  always_comb begin
    in_cell = 1'b1;
    if (line < BAND_1_START) begin
      left_bit  = code[5];
      right_bit = code[2];
    end else if (line < BAND_2_START) begin
      left_bit  = code[4];
      right_bit = code[1];
    end else if (line < CELL_LINES) begin
      left_bit  = code[3];
      right_bit = code[0];
    end else begin
      left_bit  = 1'b1;
      right_bit = 1'b1;
      in_cell   = 1'b0;
    end
  end

  always_comb begin
    dec.block_px = {{BLOCK_W{~left_bit & in_cell}}, {BLOCK_W{~right_bit & in_cell}}};
    dec.glyph_sel = code[CODE_W-1];
    if (desc) begin
      dec.glyph_blank = (line < DESC_SHIFT) || (line >= DESC_END);
      row             = line - DESC_SHIFT;
    end else begin
      dec.glyph_blank = (line >= GLYPH_ROWS);
      row             = line;
    end
    dec.rd_addr = {ch, row};
  end

endmodule

// ===== src/text_semigraphic_row_generator_core.sv =====
// ----------------------------------------------------------------------------
// Semigraphic row generator core
// Turns a character code and a scan line into one 10-pixel cell row, and
// loads the glyph store.
// ----------------------------------------------------------------------------
// The core takes one request per clock while the output is not stalled, and
// passes each render request through its stages: one stage decodes the code
// and reads the glyph store, one holds the registered store data, and one
// holds the output. Load requests write the 2048 x 7 glyph store in the decode
// stage and produce no result. A stalled output freezes the whole pipeline, so
// in_stall follows out_stall while a result is waiting. The glyph store has no
// clearing pass and must be loaded before any glyph text is rendered.
module text_semigraphic_row_generator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [sgr_pkg::CODE_W-1:0]  in_char_code,
  input  logic [sgr_pkg::LINE_W-1:0]  in_scan_row,
  input  logic [sgr_pkg::GADDR_W-1:0] in_glyph_address,
  input  logic [sgr_pkg::GLYPH_W-1:0] in_glyph_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sgr_pkg::PIX_W-1:0]   out_pixel_row
);
  import sgr_pkg::*;

  `include "text_semigraphic_row_generator_core_macros.svh"

  logic               adv;
  logic               v1_r;
  logic               mode_r;
  logic [CODE_W-1:0]  code_r;
  logic [LINE_W-1:0]  line_r;
  logic [GADDR_W-1:0] gaddr_r;
  logic [GLYPH_W-1:0] gbyte_r;
  dec_t               dec;
  logic               ram_en;
  logic [GADDR_W-1:0] ram_addr;
  logic [GLYPH_W-1:0] ram_rdata;
  logic               v2_r;
  logic [PIX_W-1:0]   blk_r;
  logic               gsel_r;
  logic               blank_r;
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_px_r;
  logic [PIX_W-1:0]   out_px_nxt;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r  <= in_mode;
      code_r  <= in_char_code;
      line_r  <= in_scan_row;
      gaddr_r <= in_glyph_address;
      gbyte_r <= in_glyph_byte;
    end
  end

  sgr_decode u_decode (
    .code (code_r),
    .line (line_r),
    .dec  (dec)
  );

  assign ram_en   = v1_r && adv;
  assign ram_addr = (mode_r == MODE_LOAD) ? gaddr_r : dec.rd_addr;

  sgr_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_DEPTH)
  ) u_glyph_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (mode_r == MODE_LOAD),
    .addr  (ram_addr),
    .wdata (gbyte_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r && (mode_r == MODE_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      blk_r   <= dec.block_px;
      gsel_r  <= dec.glyph_sel;
      blank_r <= dec.glyph_blank;
    end
  end

  always_comb begin
    if (!gsel_r) begin
      out_px_nxt = blk_r;
    end else if (blank_r) begin
      out_px_nxt = '0;
    end else begin
      out_px_nxt = {ram_rdata, {PAD_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_px_r <= out_px_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_row = out_px_r;

  `SGR_ASSERT_NEXT(a_load_no_result, clk, rst_n, v1_r && mode_r == MODE_LOAD && adv, !v2_r,
                   "load request reached the result stage")
  `SGR_ASSERT_NEXT(a_render_reaches_out, clk, rst_n, v2_r && adv, out_valid_r,
                   "render request lost before the output register")
  `SGR_ASSERT_NEXT(a_read_data_holds, clk, rst_n, v2_r && gsel_r && !blank_r && !adv,
                   $stable(ram_rdata), "glyph read data changed during a stall")

endmodule

// ===== test/text_semigraphic_row_generator_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semigraphic row generator core testbench
// Loads the glyph store and renders block-graphic and glyph-text cell rows.
// A scoreboard keeps its own copy of the glyph store and predicts every cell
// row, which is compared with each row that the core returns. The sender
// idles and the receiver stalls at random, and at times for long stretches.
// ----------------------------------------------------------------------------
module text_semigraphic_row_generator_core_test;
  import sgr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_REQUESTS = 1850;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD = 80;

  class cell_row_scoreboard;
    logic [GLYPH_W-1:0] glyph_copy [GLYPH_DEPTH];
    bit written [GLYPH_DEPTH];
    logic [PIX_W-1:0] expected_rows [$];
    int failures = 0;

    function bit drops_three_lines(logic [CHAR_W-1:0] ch);
      case (ch)
        7'd1, 7'd2, 7'd6, 7'd11, 7'd16, 7'd22, 7'd44, 7'd59,
        7'd103, 7'd106, 7'd112, 7'd113, 7'd121: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Store address read for a glyph-text row, or -1 when the row is dark.
    function int glyph_index(logic [CODE_W-1:0] code, logic [LINE_W-1:0] line);
      logic [CHAR_W-1:0] ch;
      int r;
      ch = code[CHAR_W-1:0];
      if (!drops_three_lines(ch)) begin
        if (line >= GLYPH_ROWS) return -1;
        r = int'(line);
      end else begin
        if (line < DESC_SHIFT || line >= DESC_END) return -1;
        r = int'(line - DESC_SHIFT);
      end
      return int'(ch) * 16 + r;
    endfunction

    function logic [PIX_W-1:0] predict_row(logic [CODE_W-1:0] code,
                                           logic [LINE_W-1:0] line);
      logic left_bit;
      logic right_bit;
      int idx;
      if (!code[CODE_W-1]) begin
        if (line < BAND_1_START) begin
          left_bit = code[5];
          right_bit = code[2];
        end else if (line < BAND_2_START) begin
          left_bit = code[4];
          right_bit = code[1];
        end else if (line < CELL_LINES) begin
          left_bit = code[3];
          right_bit = code[0];
        end else begin
          return '0;
        end
        return {{BLOCK_W{~left_bit}}, {BLOCK_W{~right_bit}}};
      end
      idx = glyph_index(code, line);
      if (idx < 0) return '0;
      return {glyph_copy[GADDR_W'(idx)], {PAD_W{1'b0}}};
    endfunction

    function void note_request(logic mode, logic [CODE_W-1:0] code,
                               logic [LINE_W-1:0] line,
                               logic [GADDR_W-1:0] addr,
                               logic [GLYPH_W-1:0] data);
      if (mode == MODE_LOAD) begin
        glyph_copy[addr] = data;
        written[addr] = 1'b1;
      end else begin
        expected_rows.push_back(predict_row(code, line));
      end
    endfunction

    function void check_row(logic [PIX_W-1:0] actual);
      logic [PIX_W-1:0] expected;
      if (expected_rows.size() == 0) begin
        $error("pixel_row: no row expected, actual %h", actual);
        failures++;
        return;
      end
      expected = expected_rows.pop_front();
      if (actual !== expected) begin
        $error("pixel_row: expected %h, actual %h", expected, actual);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = MODE_RENDER;
  logic [CODE_W-1:0] in_char_code = '0;
  logic [LINE_W-1:0] in_scan_row = '0;
  logic [GADDR_W-1:0] in_glyph_address = '0;
  logic [GLYPH_W-1:0] in_glyph_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] out_pixel_row;

  cell_row_scoreboard rows;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  bit long_hold_pending = 1'b0;
  int unsigned cycle_count = 0;

  text_semigraphic_row_generator_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_char_code(in_char_code),
    .in_scan_row(in_scan_row),
    .in_glyph_address(in_glyph_address),
    .in_glyph_byte(in_glyph_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pixel_row(out_pixel_row)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input logic mode, input logic [CODE_W-1:0] code,
                              input logic [LINE_W-1:0] line,
                              input logic [GADDR_W-1:0] addr,
                              input logic [GLYPH_W-1:0] data);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_char_code <= code;
    in_scan_row <= line;
    in_glyph_address <= addr;
    in_glyph_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rows.note_request(mode, code, line, addr, data);
  endtask

  task automatic drain_results();
    int wait_cycles;
    int served = 0;
    forever begin
      if (served % 120 == 0) receiver_steady = ($urandom_range(0, 3) == 0);
      wait_cycles = receiver_steady ? 0 : $urandom_range(0, 9);
      if (long_hold_pending) begin
        wait_cycles = LONG_HOLD;
        long_hold_pending = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rows.check_row(out_pixel_row);
      served++;
    end
  endtask

  task automatic run_directed();
    send_request(MODE_LOAD, 8'hff, 4'hf, {7'd0, 4'd0}, 7'h7f);
    send_request(MODE_LOAD, 8'h00, 4'h0, {7'd0, 4'd8}, 7'h41);
    send_request(MODE_LOAD, 8'h00, 4'h0, {7'd1, 4'd0}, 7'h55);
    send_request(MODE_LOAD, 8'h5a, 4'h7, {7'd1, 4'd8}, 7'h2a);
    send_request(MODE_LOAD, 8'h00, 4'h0, {7'd127, 4'd8}, 7'h01);
    send_request(MODE_LOAD, 8'h00, 4'h0, 11'h7ff, 7'h00);
    send_request(MODE_RENDER, 8'h00, 4'd0, 11'h7ff, 7'h7f);
    send_request(MODE_RENDER, 8'h7f, 4'd14, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h7f, 4'd15, 11'h7ff, 7'h7f);
    send_request(MODE_RENDER, 8'h00, 4'd15, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h2a, 4'd5, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h15, 4'd10, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h24, 4'd4, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h80, 4'd0, 11'h7ff, 7'h7f);
    send_request(MODE_RENDER, 8'h80, 4'd8, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h80, 4'd9, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h80, 4'd15, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h81, 4'd3, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h81, 4'd11, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h81, 4'd2, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h81, 4'd12, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'h81, 4'd15, 11'h000, 7'h00);
    send_request(MODE_RENDER, 8'hff, 4'd8, 11'h000, 7'h00);
  endtask

  task automatic run_random();
    int pick;
    int idx;
    logic [CODE_W-1:0] code;
    logic [LINE_W-1:0] line;
    logic [GADDR_W-1:0] addr;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) sender_steady = ($urandom_range(0, 2) == 0);
      if (n == 400 || n == 1300) long_hold_pending = 1'b1;
      pick = $urandom_range(0, 99);
      line = LINE_W'($urandom_range(0, 15));
      if (pick < 25) begin
        if ($urandom_range(0, 3) == 0) addr = GADDR_W'($urandom_range(0, GLYPH_DEPTH - 1));
        else addr = {CHAR_W'($urandom), LINE_W'($urandom_range(0, GLYPH_ROWS - 1))};
        send_request(MODE_LOAD, CODE_W'($urandom), line, addr, GLYPH_W'($urandom));
      end else if (pick < 60) begin
        code = {1'b0, CHAR_W'($urandom)};
        send_request(MODE_RENDER, code, line, GADDR_W'($urandom), GLYPH_W'($urandom));
      end else begin
        code = {1'b1, CHAR_W'($urandom)};
        idx = rows.glyph_index(code, line);
        if (idx >= 0 && !rows.written[GADDR_W'(idx)]) begin
          send_request(MODE_LOAD, CODE_W'($urandom), LINE_W'($urandom),
                       GADDR_W'(idx), GLYPH_W'($urandom));
        end
        send_request(MODE_RENDER, code, line, GADDR_W'($urandom), GLYPH_W'($urandom));
      end
    end
  endtask

  initial begin
    rows = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    fork
      drain_results();
    join_none
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (rows.expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rows.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/sgr_pkg.sv
src/sgr_ram.sv
src/sgr_decode.sv
src/text_semigraphic_row_generator_core.sv
test/text_semigraphic_row_generator_core_test.sv
